/* sv/dwa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dwa_pkg;

    // Field widths
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DUMP_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_AVERAGE    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [STATUS_W-1:0]      status;
        logic                     last_flag;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/deque_with_average.sv */
// Push, refused push, empty dump/average: item accepted, result in the output register next cycle.
// Dump: one result per cycle after acceptance while the output is free, read over the store read port.
// Average: sums the entries over the store read port, then divides in the one-bit-per-cycle divider
// with a SUM_W-bit dividend (32 + count width, 39 at DEPTH 64), then writes the mean back.
// One item at a time; a new item is accepted once the sequencer is idle and the output is free.
// Synchronous active-low reset clears pointer, count, sequencer and output valid; store undefined.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_average #(
    parameter int DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire dwa_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output dwa_pkg::t_out_item     o_item
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int SUM_W = dwa_pkg::DATA_W + CW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DUMP = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [PW-1:0]            r_front, n_front;
    logic [CW-1:0]            r_count, n_count;
    logic [PW-1:0]            r_addr, n_addr;
    logic [CW-1:0]            r_idx, n_idx;
    logic                     r_dir, n_dir;
    logic signed [SUM_W-1:0]  r_acc, n_acc;
    logic                     r_out_valid, n_out_valid;
    dwa_pkg::t_out_item       r_out, n_out;

    logic                          w_we;
    logic [PW-1:0]                 w_waddr;
    logic [dwa_pkg::DATA_W-1:0]    w_wdata;
    logic [dwa_pkg::DATA_W-1:0]    w_rdata;
    logic                          w_div_start;
    logic                          w_div_busy;
    logic [dwa_pkg::DATA_W-1:0]    w_quotient;
    logic                          w_out_free;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_last_idx;
    logic [PW-1:0]                 w_front_dec;
    logic [SW-1:0]                 w_back_sum;
    logic [SW-1:0]                 w_last_sum;
    logic [PW-1:0]                 w_back_slot;
    logic [PW-1:0]                 w_last_slot;
    logic [PW-1:0]                 w_addr_fwd;
    logic [PW-1:0]                 w_addr_bwd;
    logic [CW-1:0]                 w_count_inc;

    // Handshake
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    // Ring pointer arithmetic
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_last_idx  = (r_idx == r_count - CW'(1));
    assign w_count_inc = r_count + CW'(1);
    assign w_front_dec = (r_front == '0) ? PW'(DEPTH - 1) : r_front - PW'(1);
    assign w_back_sum  = SW'(r_front) + SW'(r_count);
    assign w_last_sum  = w_back_sum - SW'(1);
    assign w_back_slot = (w_back_sum >= SW'(DEPTH)) ? PW'(w_back_sum - SW'(DEPTH))
                                                    : PW'(w_back_sum);
    assign w_last_slot = (w_last_sum >= SW'(DEPTH)) ? PW'(w_last_sum - SW'(DEPTH))
                                                    : PW'(w_last_sum);
    assign w_addr_fwd  = (r_addr == PW'(DEPTH - 1)) ? '0 : r_addr + PW'(1);
    assign w_addr_bwd  = (r_addr == '0) ? PW'(DEPTH - 1) : r_addr - PW'(1);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_dir       = r_dir;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_front;
        w_wdata     = i_item.data_value;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.operation)
                        dwa_pkg::OP_PUSH_FRONT, dwa_pkg::OP_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out = '{result_value: '0, status: dwa_pkg::ST_FULL,
                                          last_flag: 1'b1,
                                          entry_count: dwa_pkg::COUNT_OUT_W'(r_count)};
                            end else begin
                                w_we = 1'b1;
                                if (i_item.operation == dwa_pkg::OP_PUSH_FRONT) begin
                                    w_waddr = w_front_dec;
                                    n_front = w_front_dec;
                                end else begin
                                    w_waddr = w_back_slot;
                                end
                                n_count = w_count_inc;
                                n_out = '{result_value: '0, status: dwa_pkg::ST_OK,
                                          last_flag: 1'b1,
                                          entry_count: dwa_pkg::COUNT_OUT_W'(w_count_inc)};
                            end
                        end
                        dwa_pkg::OP_DUMP_FRONT, dwa_pkg::OP_DUMP_BACK,
                        dwa_pkg::OP_AVERAGE: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{result_value: '0, status: dwa_pkg::ST_EMPTY,
                                          last_flag: 1'b1, entry_count: '0};
                            end else if (i_item.operation == dwa_pkg::OP_AVERAGE) begin
                                n_state = S_SUM;
                                n_addr  = r_front;
                                n_idx   = '0;
                                n_acc   = '0;
                            end else begin
                                n_state = S_DUMP;
                                n_dir   = (i_item.operation == dwa_pkg::OP_DUMP_BACK);
                                n_addr  = (i_item.operation == dwa_pkg::OP_DUMP_BACK)
                                          ? w_last_slot : r_front;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // One stored entry per free output slot
            S_DUMP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{result_value: w_rdata, status: dwa_pkg::ST_OK,
                              last_flag: w_last_idx,
                              entry_count: dwa_pkg::COUNT_OUT_W'(r_count)};
                    n_addr = r_dir ? w_addr_bwd : w_addr_fwd;
                    n_idx  = r_idx + CW'(1);
                    if (w_last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            // Accumulate one entry per cycle, then start the divider
            S_SUM: begin
                n_acc  = r_acc + {{(SUM_W - dwa_pkg::DATA_W){w_rdata[dwa_pkg::DATA_W-1]}},
                                  w_rdata};
                n_addr = w_addr_fwd;
                n_idx  = r_idx + CW'(1);
                if (w_last_idx) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            // Write the mean over the front entry and report it
            S_DIV: begin
                if (!w_div_busy && w_out_free) begin
                    w_we        = 1'b1;
                    w_waddr     = r_front;
                    w_wdata     = w_quotient;
                    n_out_valid = 1'b1;
                    n_out = '{result_value: w_quotient, status: dwa_pkg::ST_OK,
                              last_flag: 1'b1,
                              entry_count: dwa_pkg::COUNT_OUT_W'(r_count)};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_idx  <= n_idx;
        r_dir  <= n_dir;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    // Entry store; read address is the next walk position so data lines up with r_addr
    dwa_ram #(
        .WIDTH (dwa_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_addr),
        .o_rdata (w_rdata)
    );

    // Divider for the average
    dwa_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_acc),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

`ifndef SYNTHESIS
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == dwa_pkg::ST_FULL)
        |-> (r_out.entry_count == dwa_pkg::COUNT_OUT_W'(DEPTH)))
        else $error("full status reported with free slots");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full && (i_item.operation == dwa_pkg::OP_PUSH_FRONT
                              || i_item.operation == dwa_pkg::OP_PUSH_BACK))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted push did not grow the count");

    a_walk_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_count))
        else $error("count changed during a walk");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP || r_state == S_SUM) |-> (r_idx < r_count))
        else $error("walk index past stored entries");
`endif

endmodule

`default_nettype wire

/* sv/dwa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/dwa_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Signed-by-unsigned restoring divider, one quotient bit per cycle.
// Quotient truncates toward zero; its low word is presented.
module dwa_div #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [DIVIDEND_W-1:0]  i_dividend,
    input  wire logic [DIVISOR_W-1:0]          i_divisor,
    output logic                               o_busy,
    output logic [dwa_pkg::DATA_W-1:0]         o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                   r_busy;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_neg;
    logic [DIVIDEND_W-1:0]  r_quo;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVISOR_W-1:0]   r_dvs;

    logic [DIVIDEND_W-1:0]  w_dvd_u;
    logic [DIVIDEND_W-1:0]  w_mag;
    logic [DIVISOR_W:0]     w_shift;
    logic [DIVISOR_W:0]     w_diff;
    logic                   w_ge;
    logic [DIVIDEND_W-1:0]  w_quo_neg;

    // Magnitude of the dividend
    assign w_dvd_u = i_dividend;
    assign w_mag   = i_dividend[DIVIDEND_W-1] ? (~w_dvd_u + DIVIDEND_W'(1)) : w_dvd_u;

    // One restoring step
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIVIDEND_W-1];
            r_quo <= w_mag;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
        end
    end

    // Restore sign
    assign w_quo_neg  = ~r_quo + DIVIDEND_W'(1);
    assign o_quotient = r_neg ? w_quo_neg[dwa_pkg::DATA_W-1:0] : r_quo[dwa_pkg::DATA_W-1:0];
    assign o_busy     = r_busy;

endmodule

`default_nettype wire
